FILE: sv/cgec_pkg.sv
// Shared types and constants for the call graph edge counter.
`default_nettype none
package cgec_pkg;
    localparam int STACK_DEPTH  = 64;
    localparam int EDGE_ENTRIES = 256;
    localparam int ID_BITS      = 16;
    localparam int MAX_REPEAT   = 64;
    localparam int SP_BITS      = $clog2(STACK_DEPTH);
    localparam int LVL_BITS     = $clog2(STACK_DEPTH + 1);
    localparam int EI_BITS      = $clog2(EDGE_ENTRIES);
    localparam int EU_BITS      = $clog2(EDGE_ENTRIES + 1);
    localparam int KEY_BITS     = 2 * ID_BITS;
    localparam int REP_BITS     = 7;

    localparam logic [2:0] ST_COUNTED  = 3'd0;
    localparam logic [2:0] ST_NOCALLER = 3'd1;
    localparam logic [2:0] ST_POPPED   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic        is_call;
        logic [15:0] function_id;
        logic [15:0] file_id;
        logic [6:0]  repeat_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] caller_id;
        logic [15:0] callee_id;
        logic [31:0] edge_count;
        logic        stack_full;
        logic [6:0]  depth;
        logic        last;
    } out_item_t;

    // Lookup request and answer between the sequencer and the edge table.
    typedef struct packed {
        logic                start;
        logic [KEY_BITS-1:0] key;
    } tbl_req_t;

    typedef struct packed {
        logic        done;
        logic        full;
        logic [31:0] count;
    } tbl_rsp_t;
endpackage
`default_nettype wire

FILE: sv/cgec_table.sv
// Edge table: memory of keys and counts, scanned by one shared key comparator.
`default_nettype none
module cgec_table
    import cgec_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tbl_req_t req,
    output tbl_rsp_t      rsp
);
    typedef enum logic [2:0] {T_IDLE, T_READ, T_CMP, T_WRITE, T_DONE} tstate_t;

    logic [KEY_BITS-1:0] key_mem [EDGE_ENTRIES];
    logic [31:0]         cnt_mem [EDGE_ENTRIES];

    tstate_t             state_reg, state_next;
    logic [EU_BITS-1:0]  used_reg, used_next;
    logic [EU_BITS-1:0]  idx_reg, idx_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [31:0]         rd_cnt_reg;
    logic [31:0]         cnt_reg, cnt_next;
    logic                full_reg, full_next;
    logic                we;
    logic [EI_BITS-1:0]  wa;
    logic [31:0]         wcnt;

    // Memory: one read port, one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[wa] <= key_reg;
            cnt_mem[wa] <= wcnt;
        end
        rd_key_reg <= key_mem[idx_reg[EI_BITS-1:0]];
        rd_cnt_reg <= cnt_mem[idx_reg[EI_BITS-1:0]];
    end

    // Scan sequencer: read, compare, then update, insert, or report a full table
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        full_next  = full_reg;
        we         = 1'b0;
        wa         = idx_reg[EI_BITS-1:0];
        wcnt       = cnt_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (req.start)
                begin
                    key_next   = req.key;
                    idx_next   = '0;
                    state_next = T_READ;
                end
            end
            T_READ:
            begin
                if (idx_reg == used_reg)
                begin
                    if (used_reg == EU_BITS'(EDGE_ENTRIES))
                    begin
                        full_next  = 1'b1;
                        cnt_next   = '0;
                        state_next = T_DONE;
                    end
                    else
                    begin
                        full_next  = 1'b0;
                        cnt_next   = 32'd1;
                        state_next = T_WRITE;
                    end
                end
                else
                    state_next = T_CMP;
            end
            T_CMP:
            begin
                if (rd_key_reg == key_reg)
                begin
                    full_next  = 1'b0;
                    cnt_next   = (rd_cnt_reg == 32'hFFFF_FFFF) ? rd_cnt_reg
                                                               : rd_cnt_reg + 32'd1;
                    state_next = T_WRITE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = T_READ;
                end
            end
            T_WRITE:
            begin
                we = 1'b1;
                if (idx_reg == used_reg)
                    used_next = used_reg + 1'b1;
                state_next = T_DONE;
            end
            T_DONE:
                state_next = T_IDLE;
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            used_reg  <= '0;
            idx_reg   <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            idx_reg   <= idx_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done  = (state_reg == T_DONE);
    assign rsp.full  = full_reg;
    assign rsp.count = cnt_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= EU_BITS'(EDGE_ENTRIES)) else $error("table fill overrun");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_CMP |-> idx_reg < used_reg) else $error("scan past fill");
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> used_reg < EU_BITS'(EDGE_ENTRIES) || idx_reg < used_reg)
        else $error("insert into full table");
endmodule
`default_nettype wire

FILE: sv/call_graph_edge_counter.sv
// Top level: event sequencer, call stack and output register for the edge counter.
// Usage:
//   Input channel in/in_valid/in_ready carries one event transaction; out/out_valid/
//   out_ready carries one result per repetition, the last one flagged by last.
//   select_file is to be written via cfg_we/cfg_data only while idle; not enforced.
// Flow:
//   The block takes one event at a time and is not ready until its last result
//   has been issued. Each repetition of an enter with a caller scans the edge
//   table through one key comparator, reading and comparing the filled entries in
//   order until a match, and inserting a new edge or reporting a full table when
//   none matches. Other repetitions do not use the table. An event with zero
//   repetitions gives no result.
// Reset:
//   Clears stack level, edge table fill count and select_file. Stack and table
//   memories are not cleared; only written entries are ever read.
// Stall:
//   A result waits in the output register while the sequencer works on the
//   next repetition; the sequencer holds in emit until the register is free.
`default_nettype none
module call_graph_edge_counter
    import cgec_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    input  wire in_item_t  in,
    input  wire logic      in_valid,
    output logic           in_ready,
    output out_item_t      out,
    output logic           out_valid,
    input  wire logic      out_ready
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_STEP, S_WAIT, S_EMIT} state_t;

    logic [ID_BITS-1:0] stack_mem [STACK_DEPTH];
    state_t             state_reg;
    logic               sel_reg;
    logic [LVL_BITS-1:0] lvl_reg;
    logic [REP_BITS-1:0] rem_reg;
    logic               call_reg;
    logic [ID_BITS-1:0] callee_reg;
    logic [ID_BITS-1:0] top_reg;
    logic               tbl_start_reg;
    logic               out_valid_reg;
    out_item_t          res_reg;
    out_item_t          out_reg;
    tbl_req_t           treq;
    tbl_rsp_t           trsp;
    logic [REP_BITS-1:0] reps;
    logic               push;

    assign reps = (in.repeat_req > REP_BITS'(MAX_REPEAT)) ? REP_BITS'(MAX_REPEAT)
                                                         : in.repeat_req;
    assign push = (state_reg == S_STEP) && call_reg && (lvl_reg < LVL_BITS'(STACK_DEPTH));

    // Stack memory: write on push, registered top read
    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[lvl_reg[SP_BITS-1:0]] <= callee_reg;
        top_reg <= stack_mem[SP_BITS'(lvl_reg - 1'b1)];
    end

    assign treq.start = tbl_start_reg;
    assign treq.key   = {top_reg, callee_reg};

    cgec_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (treq),
        .rsp   (trsp)
    );

    // Sequencer: one repetition per pass, result built in a work register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            lvl_reg       <= '0;
            rem_reg       <= '0;
            call_reg      <= 1'b0;
            callee_reg    <= '0;
            tbl_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            tbl_start_reg <= (state_reg == S_STEP) && call_reg && (lvl_reg != '0);
            if (cfg_we)
                sel_reg <= cfg_data;
            // Issue the finished result, or drop valid once it is taken
            if ((state_reg == S_EMIT) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        call_reg   <= in.is_call;
                        callee_reg <= sel_reg ? in.file_id : in.function_id;
                        rem_reg    <= reps;
                        if (reps != '0)
                            state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_STEP;
                S_STEP:
                begin
                    res_reg.caller_id  <= (call_reg && (lvl_reg != '0)) ? top_reg : '0;
                    res_reg.callee_id  <= call_reg ? callee_reg : '0;
                    res_reg.edge_count <= '0;
                    res_reg.stack_full <= call_reg && !push;
                    res_reg.last       <= (rem_reg == REP_BITS'(1));
                    if (call_reg)
                    begin
                        if (push)
                            lvl_reg <= lvl_reg + 1'b1;
                        res_reg.depth <= 7'(push ? lvl_reg + 1'b1 : lvl_reg);
                        if (lvl_reg != '0)
                        begin
                            res_reg.status <= ST_COUNTED;
                            state_reg      <= S_WAIT;
                        end
                        else
                        begin
                            res_reg.status <= ST_NOCALLER;
                            state_reg      <= S_EMIT;
                        end
                    end
                    else if (lvl_reg != '0)
                    begin
                        lvl_reg        <= lvl_reg - 1'b1;
                        res_reg.depth  <= 7'(lvl_reg - 1'b1);
                        res_reg.status <= ST_POPPED;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        res_reg.depth  <= '0;
                        res_reg.status <= ST_EMPTY;
                        state_reg      <= S_EMIT;
                    end
                end
                S_WAIT:
                begin
                    if (trsp.done)
                    begin
                        res_reg.status     <= trsp.full ? ST_FULL : ST_COUNTED;
                        res_reg.edge_count <= trsp.count;
                        state_reg          <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        rem_reg   <= rem_reg - 1'b1;
                        state_reg <= (rem_reg == REP_BITS'(1)) ? S_IDLE : S_READ;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out       = out_reg;

    a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_BITS'(STACK_DEPTH)) else $error("stack level overrun");
    a_busy_reps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> rem_reg != '0) else $error("step with no repetitions");
    a_tbl_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
        trsp.done |-> state_reg == S_WAIT) else $error("stray table answer");
endmodule
`default_nettype wire

FILE: sim/call_graph_edge_counter_checker.sv
// Checker for the call graph edge counter: predicts results and compares them.
`default_nettype none
module call_graph_edge_counter_checker
    import cgec_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    input  wire in_item_t  in,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire out_item_t out,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    output int             fail_count,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] shadow_stack [STACK_DEPTH];
    int          stack_top;
    logic [31:0] edge_key_tbl [EDGE_ENTRIES];
    logic [31:0] edge_cnt_tbl [EDGE_ENTRIES];
    int          edges_filled;
    logic        by_file;
    out_item_t   expected_results [$];

    // Count one edge; return its status and new count
    function automatic void count_edge(input logic [31:0] key, output logic [2:0] st,
                                       output logic [31:0] cnt);
        for (int i = 0; i < edges_filled; i++)
        begin
            if (edge_key_tbl[i] == key)
            begin
                if (edge_cnt_tbl[i] != 32'hFFFF_FFFF)
                    edge_cnt_tbl[i]++;
                cnt = edge_cnt_tbl[i];
                st = ST_COUNTED;
                return;
            end
        end
        if (edges_filled < EDGE_ENTRIES)
        begin
            edge_key_tbl[edges_filled] = key;
            edge_cnt_tbl[edges_filled] = 1;
            edges_filled++;
            cnt = 1;
            st = ST_COUNTED;
        end
        else
        begin
            cnt = 0;
            st = ST_FULL;
        end
    endfunction

    // Apply one event and queue its results
    function automatic void apply_event(input in_item_t ev);
        int        reps;
        out_item_t r;
        logic      have;
        reps = (ev.repeat_req > MAX_REPEAT) ? MAX_REPEAT : ev.repeat_req;
        for (int k = 0; k < reps; k++)
        begin
            r = '0;
            if (ev.is_call)
            begin
                have = stack_top > 0;
                r.callee_id = by_file ? ev.file_id : ev.function_id;
                if (have)
                    r.caller_id = shadow_stack[stack_top - 1];
                if (stack_top < STACK_DEPTH)
                    shadow_stack[stack_top++] = r.callee_id;
                else
                    r.stack_full = 1'b1;
                if (have)
                    count_edge({r.caller_id, r.callee_id}, r.status, r.edge_count);
                else
                    r.status = ST_NOCALLER;
            end
            else if (stack_top > 0)
            begin
                stack_top--;
                r.status = ST_POPPED;
            end
            else
            begin
                r.status = ST_EMPTY;
            end
            r.depth = stack_top[6:0];
            r.last = (k + 1 == reps);
            expected_results.push_back(r);
        end
    endfunction

    // Track configuration, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            stack_top = 0;
            edges_filled = 0;
            by_file = 1'b0;
            fail_count = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                by_file = cfg_data;
            if (in_valid && in_ready)
                apply_event(in);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, out);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out !== exp_r)
                    begin
                        $display("%0t: result differs, expected %p, actual %p",
                                 $time, exp_r, out);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end
endmodule
`default_nettype wire

FILE: sim/call_graph_edge_counter_tb.sv
// Testbench top for the call graph edge counter: stimulus, clock and verdict.
`default_nettype none
module call_graph_edge_counter_tb;
    import cgec_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 40_000_000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_data = 1'b0;
    in_item_t  in = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    out_item_t out;
    logic      out_valid;
    logic      out_ready = 1'b0;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        out_hold = 0;
    logic [15:0] id_pool [8];

    always #10 clk = ~clk;

    call_graph_edge_counter u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in(in), .in_valid(in_valid), .in_ready(in_ready),
        .out(out), .out_valid(out_valid), .out_ready(out_ready)
    );

    call_graph_edge_counter_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in(in), .in_valid(in_valid), .in_ready(in_ready),
        .out(out), .out_valid(out_valid), .out_ready(out_ready),
        .fail_count(fail_count), .pending(pending)
    );

    // Hold off each result a random number of cycles, with stretches of none
    always @(posedge clk)
    begin
        int hold_next;
        hold_next = out_hold;
        if (out_valid && out_ready)
            hold_next = (cycle_count % 4000 < 800) ? 0 : $urandom_range(0, 6);
        else if (out_valid && out_hold > 0)
            hold_next = out_hold - 1;
        out_hold <= hold_next;
        out_ready <= (hold_next == 0);
    end

    // Guard against a hang
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("call_graph_edge_counter: mismatch");
            $finish;
        end
    end

    // Send one event transaction after a random gap
    task automatic send_event(input logic call, input logic [15:0] fid,
                              input logic [15:0] flid, input logic [6:0] reps);
        int gap;
        gap = (cycle_count % 4000 < 800) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in <= '{is_call: call, function_id: fid, file_id: flid, repeat_req: reps};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Wait until every result is in, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_select(input logic value);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random event, mostly calls and returns drawn from a small id pool
    task automatic random_event();
        logic       call;
        logic [6:0] reps;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) reps = 7'($urandom_range(65, 127));
        else if (pick < 10) reps = 0;
        else if (pick < 15) reps = 7'($urandom_range(1, 64));
        else reps = 7'($urandom_range(1, 3));
        call = ($urandom_range(0, 99) < 55);
        if ($urandom_range(0, 9) == 0)
            send_event(call, 16'($urandom), 16'($urandom), reps);
        else
            send_event(call, id_pool[$urandom_range(0, 7)],
                       id_pool[$urandom_range(0, 7)], reps);
    endtask

    initial
    begin
        foreach (id_pool[i]) id_pool[i] = 16'($urandom);
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: exit on empty, enter with no caller, edge counting, extremes
        send_event(1'b0, 16'h1234, 16'h5678, 7'd2);
        send_event(1'b1, 16'h0000, 16'hFFFF, 7'd1);
        send_event(1'b1, 16'hFFFF, 16'h0000, 7'd3);
        send_event(1'b1, 16'hAAAA, 16'h5555, 7'd0);
        send_event(1'b0, 16'h0000, 16'h0000, 7'd2);
        send_event(1'b1, 16'h5555, 16'hAAAA, 7'd127);
        drain();
        // Stack is full here: a further enter is skipped but counted
        send_event(1'b1, 16'h0F0F, 16'hF0F0, 7'd2);
        write_select(1'b1);
        send_event(1'b1, 16'h0F0F, 16'hF0F0, 7'd2);
        send_event(1'b0, 16'h0000, 16'h0000, 7'd64);
        send_event(1'b0, 16'h0000, 16'h0000, 7'd70);
        write_select(1'b0);

        // Fill the edge table to overflow: two new edges per enter, one on an empty stack
        send_event(1'b1, 16'h0001, 16'h0001, 7'd1);
        for (int i = 0; i < 140; i++)
        begin
            send_event(1'b1, 16'(16'h0100 + i), 16'h0, 7'd2);
            if (i % 32 == 31)
                send_event(1'b0, 16'h0, 16'h0, 7'd64);
        end
        drain();

        // Random events across settings, pausing until everything arrives at i == 40, 60 and 80
        for (int i = 0; i < 120; i++)
        begin
            if (i == 40) write_select(1'b1);
            if (i == 80) write_select(1'b0);
            if (i == 60) drain();
            random_event();
        end
        drain();

        if (fail_count == 0)
            $display("call_graph_edge_counter: match");
        else
            $display("call_graph_edge_counter: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
sv/cgec_pkg.sv
sv/cgec_table.sv
sv/call_graph_edge_counter.sv
sim/call_graph_edge_counter_checker.sv
sim/call_graph_edge_counter_tb.sv
